// ===== hw/rtl/ttip_pkg.sv =====
// ttip_pkg: shared types and constants of the text-to-integer parser.
// Used by ttip_front, ttip_back and checked_text_to_integer_parser; no dependencies.
package ttip_pkg;

	localparam int MID_DEPTH = 2;
	localparam int OUT_DEPTH = 2;

	typedef enum logic [1:0] {
		CFG_SIGNED = 2'd0,
		CFG_BASE   = 2'd1,
		CFG_WIDTH  = 2'd2,
		CFG_SUFFIX = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		W8  = 2'd0,
		W16 = 2'd1,
		W32 = 2'd2,
		W64 = 2'd3
	} wsel_t;

	typedef enum logic [1:0] {
		SFX_NONE  = 2'd0,
		SFX_SEC   = 2'd1,
		SFX_PCT   = 2'd2,
		SFX_BYTES = 2'd3
	} sfx_mode_t;

	typedef struct packed {
		logic      signed_mode;
		logic      base_mode;
		wsel_t     width_select;
		sfx_mode_t suffix_mode;
	} cfg_t;

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_SPACE  = 3'd1,
		PH_SIGN   = 3'd2,
		PH_ZERO   = 3'd3,
		PH_HEXPFX = 3'd4,
		PH_DIGITS = 3'd5,
		PH_SUFFIX = 3'd6,
		PH_JUNK   = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_OCT = 2'd1,
		RX_HEX = 2'd2
	} radix_t;

	typedef enum logic [3:0] {
		SP_NONE = 4'd0,
		SP_S    = 4'd1,
		SP_SE   = 4'd2,
		SP_SEC  = 4'd3,
		SP_PCT  = 4'd4,
		SP_K    = 4'd5,
		SP_M    = 4'd6,
		SP_G    = 4'd7,
		SP_T    = 4'd8,
		SP_P    = 4'd9,
		SP_KB   = 4'd10,
		SP_MB   = 4'd11,
		SP_GB   = 4'd12,
		SP_TB   = 4'd13,
		SP_PB   = 4'd14
	} sfx_prog_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FORMAT   = 3'd1,
		ST_OVERFLOW = 3'd2,
		ST_RANGE    = 3'd3,
		ST_MINUS    = 3'd4
	} status_t;

	// character class of one beat
	typedef struct packed {
		logic      eot;
		logic      blank;
		logic      plus;
		logic      minus;
		logic      zero;
		logic      x;
		logic      dig_ok;
		logic [3:0] dval;
		logic      s;
		logic      e;
		logic      c;
		logic      pct;
		logic      b;
		sfx_prog_t unit;
	} cls_t;

endpackage

// ===== hw/rtl/ttip_fifo.sv =====
// ttip_fifo: small register queue, WIDTH bits by DEPTH entries (DEPTH >= 2).
// Generic; no package dependencies.
module ttip_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             push_ok, pop_ok;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push_ok) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop_ok) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

endmodule

// ===== hw/rtl/ttip_front.sv =====
// ttip_front: classifies one input beat into character classes.
// Depends on ttip_pkg (cls_t, sfx_prog_t).
module ttip_front import ttip_pkg::*; (
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	output cls_t       cls
);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LC    = 8'h63;
	localparam logic [7:0] CH_LE    = 8'h65;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LG    = 8'h67;
	localparam logic [7:0] CH_LK    = 8'h6B;
	localparam logic [7:0] CH_LM    = 8'h6D;
	localparam logic [7:0] CH_LP    = 8'h70;
	localparam logic [7:0] CH_LS    = 8'h73;
	localparam logic [7:0] CH_LT    = 8'h74;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] HEX_OFS  = 8'h57;

	logic [7:0] lc;
	logic       is_dec, is_hexl;

	assign lc      = char_code | 8'h20;
	assign is_dec  = char_code >= CH_0 && char_code <= CH_9;
	assign is_hexl = lc >= CH_LA && lc <= CH_LF;

	always_comb begin
		logic [7:0] hv;
		hv          = lc - HEX_OFS;
		cls.eot     = end_of_text;
		cls.blank   = char_code == CH_SPACE || (char_code >= CH_TAB && char_code <= CH_CR);
		cls.plus    = char_code == CH_PLUS;
		cls.minus   = char_code == CH_MINUS;
		cls.zero    = char_code == CH_0;
		cls.x       = lc == CH_LX;
		cls.dig_ok  = is_dec || is_hexl;
		cls.dval    = is_dec ? char_code[3:0] : hv[3:0];
		cls.s       = char_code == CH_LS;
		cls.e       = char_code == CH_LE;
		cls.c       = char_code == CH_LC;
		cls.pct     = char_code == CH_PCT;
		cls.b       = lc == CH_LB;
		if (lc == CH_LK) begin
			cls.unit = SP_K;
		end else if (lc == CH_LM) begin
			cls.unit = SP_M;
		end else if (lc == CH_LG) begin
			cls.unit = SP_G;
		end else if (lc == CH_LT) begin
			cls.unit = SP_T;
		end else if (lc == CH_LP) begin
			cls.unit = SP_P;
		end else begin
			cls.unit = SP_NONE;
		end
	end

endmodule

// ===== hw/rtl/ttip_back.sv =====
// ttip_back: parse state machine with digit accumulator and a finish stage.
// Depends on ttip_pkg (cfg_t, cls_t, phase_t, radix_t, sfx_prog_t, status_t).
module ttip_back import ttip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_empty,
	input  cls_t        q_item,
	output logic        q_pop,
	input  logic        out_full,
	output logic        res_valid,
	output logic [63:0] res_value,
	output status_t     res_status
);

	phase_t    phase_q, n_phase;
	logic [63:0] acc_q, n_acc;
	logic      neg_q, n_neg;
	radix_t    radix_q, n_radix;
	logic      ovf_q, n_ovf;
	logic      anyd_q, n_anyd;
	sfx_prog_t sp_q, n_sp;
	status_t   err_q, n_err;

	logic        fin_v_s1;
	phase_t      ph_s1;
	logic [63:0] acc_s1;
	logic        neg_s1, ovf_s1, anyd_s1;
	sfx_prog_t   sp_s1;
	status_t     err_s1;

	logic        fin_free, take, dec_only, in_radix;
	logic [67:0] mul;
	logic [68:0] sum;

	assign fin_free  = !fin_v_s1 || !out_full;
	assign take      = !q_empty && (!q_item.eot || fin_free);
	assign q_pop     = take;
	assign res_valid = fin_v_s1 && !out_full;
	assign dec_only  = cfg.base_mode || cfg.suffix_mode == SFX_BYTES;

	always_comb begin
		unique case (radix_q)
			RX_HEX:  mul = {acc_q, 4'b0};
			RX_OCT:  mul = {1'b0, acc_q, 3'b0};
			default: mul = {1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0};
		endcase
		sum = {1'b0, mul} + {65'b0, q_item.dval};
		unique case (radix_q)
			RX_HEX:  in_radix = q_item.dig_ok;
			RX_OCT:  in_radix = q_item.dig_ok && q_item.dval < 4'd8;
			default: in_radix = q_item.dig_ok && q_item.dval < 4'd10;
		endcase
	end

	always_comb begin
		n_phase = phase_q;
		n_acc   = acc_q;
		n_neg   = neg_q;
		n_radix = radix_q;
		n_ovf   = ovf_q;
		n_anyd  = anyd_q;
		n_sp    = sp_q;
		n_err   = err_q;
		if (take && q_item.eot) begin
			n_phase = PH_START;
			n_acc   = '0;
			n_neg   = 1'b0;
			n_radix = RX_DEC;
			n_ovf   = 1'b0;
			n_anyd  = 1'b0;
			n_sp    = SP_NONE;
			n_err   = ST_OK;
		end else if (take) begin
			unique case (phase_q)
				PH_START, PH_SPACE, PH_SIGN: begin
					if (phase_q != PH_SIGN && q_item.blank) begin
						n_phase = PH_SPACE;
					end else if (phase_q != PH_SIGN && q_item.plus) begin
						n_phase = PH_SIGN;
					end else if (phase_q != PH_SIGN && q_item.minus) begin
						if (cfg.signed_mode && cfg.suffix_mode == SFX_NONE) begin
							n_neg   = 1'b1;
							n_phase = PH_SIGN;
						end else begin
							n_err   = ST_MINUS;
							n_phase = PH_JUNK;
						end
					end else if (!dec_only && q_item.zero) begin
						n_radix = RX_OCT;
						n_anyd  = 1'b1;
						n_acc   = '0;
						n_phase = PH_ZERO;
					end else if (q_item.dig_ok && q_item.dval < 4'd10) begin
						n_radix = RX_DEC;
						n_anyd  = 1'b1;
						n_acc   = {60'b0, q_item.dval};
						n_phase = PH_DIGITS;
					end else begin
						n_err   = ST_FORMAT;
						n_phase = PH_JUNK;
					end
				end
				PH_ZERO, PH_DIGITS: begin
					if (phase_q == PH_ZERO && q_item.x) begin
						n_phase = PH_HEXPFX;
					end else if (in_radix) begin
						n_anyd  = 1'b1;
						n_phase = PH_DIGITS;
						if (!ovf_q) begin
							if (sum[68:64] != '0) begin
								n_ovf = 1'b1;
							end else begin
								n_acc = sum[63:0];
							end
						end
					end else begin
						n_phase = PH_SUFFIX;
						if (cfg.suffix_mode == SFX_SEC && q_item.s) begin
							n_sp = SP_S;
						end else if (cfg.suffix_mode == SFX_PCT && q_item.pct) begin
							n_sp = SP_PCT;
						end else if (cfg.suffix_mode == SFX_BYTES && q_item.unit != SP_NONE) begin
							n_sp = q_item.unit;
						end else begin
							n_err   = ST_FORMAT;
							n_phase = PH_JUNK;
						end
					end
				end
				PH_HEXPFX: begin
					if (q_item.dig_ok) begin
						n_radix = RX_HEX;
						n_anyd  = 1'b1;
						n_acc   = {60'b0, q_item.dval};
						n_phase = PH_DIGITS;
					end else begin
						n_err   = ST_FORMAT;
						n_phase = PH_JUNK;
					end
				end
				PH_SUFFIX: begin
					if (sp_q == SP_S && q_item.e) begin
						n_sp = SP_SE;
					end else if (sp_q == SP_SE && q_item.c) begin
						n_sp = SP_SEC;
					end else if (q_item.b && sp_q == SP_K) begin
						n_sp = SP_KB;
					end else if (q_item.b && sp_q == SP_M) begin
						n_sp = SP_MB;
					end else if (q_item.b && sp_q == SP_G) begin
						n_sp = SP_GB;
					end else if (q_item.b && sp_q == SP_T) begin
						n_sp = SP_TB;
					end else if (q_item.b && sp_q == SP_P) begin
						n_sp = SP_PB;
					end else begin
						n_err   = ST_FORMAT;
						n_phase = PH_JUNK;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			acc_q    <= '0;
			neg_q    <= 1'b0;
			radix_q  <= RX_DEC;
			ovf_q    <= 1'b0;
			anyd_q   <= 1'b0;
			sp_q     <= SP_NONE;
			err_q    <= ST_OK;
			fin_v_s1 <= 1'b0;
		end else begin
			phase_q <= n_phase;
			acc_q   <= n_acc;
			neg_q   <= n_neg;
			radix_q <= n_radix;
			ovf_q   <= n_ovf;
			anyd_q  <= n_anyd;
			sp_q    <= n_sp;
			err_q   <= n_err;
			if (take && q_item.eot) begin
				fin_v_s1 <= 1'b1;
			end else if (res_valid) begin
				fin_v_s1 <= 1'b0;
			end
		end
	end

	// snapshot of the parse at the terminator
	always_ff @(posedge clk) begin
		if (take && q_item.eot) begin
			ph_s1   <= phase_q;
			acc_s1  <= acc_q;
			neg_s1  <= neg_q;
			ovf_s1  <= ovf_q;
			anyd_s1 <= anyd_q;
			sp_s1   <= sp_q;
			err_s1  <= err_q;
		end
	end

	function automatic logic range_ok(logic [63:0] mag, logic neg, logic sgn, wsel_t ws);
		logic hi_u, hi_s, half_eq;
		unique case (ws)
			W8: begin
				hi_u    = |mag[63:8];
				hi_s    = |mag[63:7];
				half_eq = mag == 64'h80;
			end
			W16: begin
				hi_u    = |mag[63:16];
				hi_s    = |mag[63:15];
				half_eq = mag == 64'h8000;
			end
			W32: begin
				hi_u    = |mag[63:32];
				hi_s    = |mag[63:31];
				half_eq = mag == 64'h8000_0000;
			end
			default: begin
				hi_u    = 1'b0;
				hi_s    = 1'b0;
				half_eq = 1'b1;
			end
		endcase
		if (!sgn) begin
			return !hi_u;
		end
		return !hi_s || (neg && half_eq);
	endfunction

	always_comb begin
		logic        slim, complete, big;
		logic [63:0] v;
		slim = (cfg.signed_mode && cfg.suffix_mode == SFX_NONE) ||
		       cfg.suffix_mode == SFX_SEC || cfg.suffix_mode == SFX_PCT;
		complete = sp_s1 == SP_S || sp_s1 == SP_SEC || sp_s1 == SP_PCT ||
		           sp_s1 == SP_KB || sp_s1 == SP_MB || sp_s1 == SP_GB ||
		           sp_s1 == SP_TB || sp_s1 == SP_PB;
		big = neg_s1 ? (acc_s1[63] && |acc_s1[62:0]) : acc_s1[63];
		v   = neg_s1 ? 64'd0 - acc_s1 : acc_s1;
		if (ph_s1 == PH_SUFFIX) begin
			unique case (sp_s1)
				SP_KB:   v = v << 10;
				SP_MB:   v = v << 20;
				SP_GB:   v = v << 30;
				SP_TB:   v = v << 40;
				SP_PB:   v = v << 50;
				default: v = v;
			endcase
		end
		if (cfg.suffix_mode == SFX_SEC || cfg.suffix_mode == SFX_PCT) begin
			v = {32'b0, v[31:0]};
		end
		res_value = '0;
		priority if (err_s1 == ST_MINUS) begin
			res_status = ST_MINUS;
		end else if (ph_s1 == PH_START) begin
			res_status = ST_OK;
		end else if (ovf_s1 || (slim && big)) begin
			res_status = ST_OVERFLOW;
		end else if (err_s1 != ST_OK || !anyd_s1 || ph_s1 == PH_HEXPFX ||
		             (ph_s1 == PH_SUFFIX && !complete)) begin
			res_status = ST_FORMAT;
		end else if (cfg.suffix_mode == SFX_NONE &&
		             !range_ok(acc_s1, neg_s1, cfg.signed_mode, cfg.width_select)) begin
			res_status = ST_RANGE;
		end else begin
			res_status = ST_OK;
			res_value  = v;
		end
	end

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fin_v_s1 && out_full |=> fin_v_s1)
		else $error("finish stage dropped a stalled result");

	a_junk_err: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_JUNK |-> err_q != ST_OK)
		else $error("junk phase without an error code");

	a_nodig_acc: assert property (@(posedge clk) disable iff (!arst_n)
		!anyd_q |-> acc_q == '0 && !ovf_q)
		else $error("accumulator set before any digit");

	a_sfx_phase: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q != SP_NONE |-> phase_q == PH_SUFFIX || phase_q == PH_JUNK)
		else $error("suffix progress outside suffix phase");

endmodule

// ===== hw/rtl/checked_text_to_integer_parser.sv =====
// checked_text_to_integer_parser: top level; classifier, beat queue, parser, result queue.
// Depends on ttip_pkg, ttip_front, ttip_fifo, ttip_back.
//
//  channel   handshake            payload
//  input     push / full          char_code[7:0], end_of_text
//  result    pop / empty          parsed_value[63:0], status[2:0]
//  config    cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[1:0]
//
// One beat per cycle unless a terminator meets a stalled finish stage; the parser's
// accumulate step (x radix + digit) is registered per beat, so digits follow directly.
// A terminator beat passes the beat queue, the finish stage and the result queue to the ports.
// Reset clears both queues and the parse state; registers go to their defaults.
// A stalled result queue holds the finish stage; the next terminator then waits
// in the beat queue, and full rises once that queue fills.
module checked_text_to_integer_parser import ttip_pkg::*; #(
	parameter int MID_DEPTH_P = MID_DEPTH,
	parameter int OUT_DEPTH_P = OUT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_code,
	input  logic        end_of_text,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] parsed_value,
	output logic [2:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data
);

	localparam int CLS_W = $bits(cls_t);
	localparam int RES_W = 64 + 3;

	cfg_t             cfg_q;
	cls_t             cls_in;
	logic [CLS_W-1:0] mid_rd;
	logic             mid_empty, mid_pop;
	logic             out_full, res_valid;
	logic [63:0]      res_value;
	status_t          res_status;
	logic [RES_W-1:0] out_rd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.signed_mode  <= 1'b0;
			cfg_q.base_mode    <= 1'b0;
			cfg_q.width_select <= W64;
			cfg_q.suffix_mode  <= SFX_NONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SIGNED: cfg_q.signed_mode  <= cfg_data[0];
				CFG_BASE:   cfg_q.base_mode    <= cfg_data[0];
				CFG_WIDTH:  cfg_q.width_select <= wsel_t'(cfg_data);
				CFG_SUFFIX: cfg_q.suffix_mode  <= sfx_mode_t'(cfg_data);
			endcase
		end
	end

	ttip_front u_front (
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.cls         (cls_in)
	);

	ttip_fifo #(
		.WIDTH (CLS_W),
		.DEPTH (MID_DEPTH_P)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (cls_in),
		.full    (full),
		.pop     (mid_pop),
		.rd_data (mid_rd),
		.empty   (mid_empty)
	);

	ttip_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (mid_empty),
		.q_item     (cls_t'(mid_rd)),
		.q_pop      (mid_pop),
		.out_full   (out_full),
		.res_valid  (res_valid),
		.res_value  (res_value),
		.res_status (res_status)
	);

	ttip_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH_P)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_valid),
		.wr_data ({res_value, res_status}),
		.full    (out_full),
		.pop     (pop),
		.rd_data (out_rd),
		.empty   (empty)
	);

	assign parsed_value = out_rd[RES_W-1:3];
	assign status       = out_rd[2:0];

endmodule
